@@ design/mcbp_pkg.sv @@
package mcbp_pkg;

  // fixed field widths of the stream items
  localparam int REQ_W    = 2;
  localparam int CH_W     = 3;
  localparam int BYTE_W   = 8;
  localparam int RCNT_W   = 5;
  localparam int STATUS_W = 3;
  localparam int FILL_W   = 7;

  // request codes
  localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
  localparam logic [REQ_W-1:0] REQ_WRITE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NONE    = 3'd4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RD_DATA
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture the input item
    logic single;    // emit the one result of a non-burst request and update state
    logic rd_issue;  // pop one byte: memory read at tail, advance tail, drop count
    logic rd_push;   // move the popped byte into the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic drop;       // request gives no result
    logic burst;      // read of a busy, non-empty pipe
    logic slot_free;  // output register can take an item this cycle
    logic more;       // another byte follows the pending one
  } sts_t;

endpackage

@@ design/mcbp_ram.sv @@
module mcbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/mcbp_ctrl.sv @@
module mcbp_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  mcbp_pkg::sts_t sts,
  output mcbp_pkg::cmd_t cmd
);

  import mcbp_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.drop) begin
          state_next = S_IDLE;
        end else if (sts.burst) begin
          state_next = S_RD_DATA;
        end else if (sts.slot_free) begin
          state_next = S_IDLE;
        end
      end
      S_RD_DATA: begin
        if (sts.slot_free && !sts.more) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    s_tready     = 1'b0;
    cmd          = '0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      S_EXEC: begin
        cmd.single   = !sts.drop && !sts.burst && sts.slot_free;
        cmd.rd_issue = !sts.drop && sts.burst;
      end
      S_RD_DATA: begin
        cmd.rd_push  = sts.slot_free;
        cmd.rd_issue = sts.slot_free && sts.more;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

endmodule

@@ design/mcbp_dp.sv @@
module mcbp_dp #(
  parameter int NUM_PIPES  = 8,
  parameter int PIPE_DEPTH = 64,
  parameter int MAX_BURST  = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  mcbp_pkg::cmd_t                  cmd,
  output mcbp_pkg::sts_t                  sts,
  input  logic [mcbp_pkg::REQ_W-1:0]      req_type,
  input  logic [mcbp_pkg::CH_W-1:0]       channel,
  input  logic [mcbp_pkg::BYTE_W-1:0]     write_byte,
  input  logic [mcbp_pkg::RCNT_W-1:0]     read_count,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [mcbp_pkg::STATUS_W-1:0]   status,
  output logic [mcbp_pkg::CH_W-1:0]       result_channel,
  output logic [mcbp_pkg::BYTE_W-1:0]     read_byte,
  output logic [mcbp_pkg::FILL_W-1:0]     fill_level,
  output logic                            last
);

  import mcbp_pkg::*;

  localparam int PIDX_W = (NUM_PIPES > 1) ? $clog2(NUM_PIPES) : 1;
  localparam int IDX_W  = $clog2(PIPE_DEPTH);
  localparam int FCNT_W = $clog2(PIPE_DEPTH + 1);
  localparam int REM_W  = $clog2(MAX_BURST + 1);
  localparam int ADDR_W = $clog2(NUM_PIPES * PIPE_DEPTH);
  localparam int SAT_W  = 7;

  // captured request
  logic [REQ_W-1:0]  req_q;
  logic [CH_W-1:0]   ch_q;
  logic [BYTE_W-1:0] wb_q;
  logic [RCNT_W-1:0] cnt_q;
  logic [REM_W-1:0]  rem_q;

  // per-pipe control state
  logic              busy  [NUM_PIPES];
  logic [IDX_W-1:0]  head  [NUM_PIPES];
  logic [IDX_W-1:0]  tail  [NUM_PIPES];
  logic [FCNT_W-1:0] count [NUM_PIPES];

  // byte popped but not yet in the output register
  logic [FCNT_W-1:0] pend_fill;
  logic              pend_last;

  logic [PIDX_W-1:0] pidx;
  logic              ch_in_range;
  logic              sel_busy;
  logic [IDX_W-1:0]  sel_head;
  logic [IDX_W-1:0]  sel_tail;
  logic [FCNT_W-1:0] sel_count;
  logic [IDX_W-1:0]  head_inc;
  logic [IDX_W-1:0]  tail_inc;
  logic              full;
  logic              wr_ok;
  logic              free_found;
  logic [PIDX_W-1:0] free_idx;
  logic [SAT_W-1:0]  cnt_wide;
  logic [SAT_W-1:0]  cnt_sat;
  logic [ADDR_W-1:0] base;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  logic [BYTE_W-1:0] rdata;

  logic [STATUS_W-1:0] one_status;
  logic [CH_W-1:0]     one_ch;
  logic [FCNT_W-1:0]   one_fill;

  assign pidx        = PIDX_W'(ch_q);
  assign ch_in_range = 32'(ch_q) < NUM_PIPES;
  assign sel_busy    = ch_in_range && busy[pidx];
  assign sel_head    = head[pidx];
  assign sel_tail    = tail[pidx];
  assign sel_count   = count[pidx];
  assign head_inc    = (sel_head == IDX_W'(PIPE_DEPTH - 1)) ? '0 : sel_head + 1'b1;
  assign tail_inc    = (sel_tail == IDX_W'(PIPE_DEPTH - 1)) ? '0 : sel_tail + 1'b1;
  assign full        = (sel_count == FCNT_W'(PIPE_DEPTH));
  assign wr_ok       = (req_q == REQ_WRITE) && sel_busy && !full;

  // lowest free pipe
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_PIPES - 1; i >= 0; i--) begin
      if (!busy[i]) begin
        free_found = 1'b1;
        free_idx   = PIDX_W'(i);
      end
    end
  end

  // burst length saturates at MAX_BURST
  assign cnt_wide = SAT_W'(read_count);
  assign cnt_sat  = (cnt_wide > SAT_W'(MAX_BURST)) ? SAT_W'(MAX_BURST) : cnt_wide;

  assign sts.drop      = ((req_q == REQ_READ) && (cnt_q == '0)) ||
                         !(req_q inside {REQ_ALLOC, REQ_WRITE, REQ_READ});
  assign sts.burst     = (req_q == REQ_READ) && (cnt_q != '0) && sel_busy &&
                         (sel_count != '0);
  assign sts.slot_free = !out_valid || out_ready;
  assign sts.more      = !pend_last;

  // pipe region of the shared byte memory
  assign base  = ADDR_W'(pidx) * ADDR_W'(PIPE_DEPTH);
  assign waddr = base + ADDR_W'(sel_head);
  assign raddr = base + ADDR_W'(sel_tail);

  mcbp_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (NUM_PIPES * PIPE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.single && wr_ok),
    .waddr (waddr),
    .wdata (wb_q),
    .re    (cmd.rd_issue),
    .raddr (raddr),
    .rdata (rdata)
  );

  // result of a request that gives exactly one item
  always_comb begin
    one_status = ST_INVALID;
    one_ch     = ch_q;
    one_fill   = '0;
    case (req_q)
      REQ_ALLOC: begin
        if (free_found) begin
          one_status = ST_OK;
          one_ch     = CH_W'(free_idx);
          one_fill   = count[free_idx];
        end else begin
          one_status = ST_NONE;
          one_ch     = '0;
        end
      end
      REQ_WRITE: begin
        if (!sel_busy) begin
          one_status = ST_INVALID;
        end else if (full) begin
          one_status = ST_FULL;
          one_fill   = sel_count;
        end else begin
          one_status = ST_OK;
          one_fill   = sel_count + 1'b1;
        end
      end
      REQ_READ: begin
        if (!sel_busy) begin
          one_status = ST_INVALID;
        end else begin
          one_status = ST_EMPTY;
        end
      end
      default: begin
        one_status = ST_INVALID;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q <= req_type;
      ch_q  <= channel;
      wb_q  <= write_byte;
      cnt_q <= read_count;
      rem_q <= REM_W'(cnt_sat);
    end else if (cmd.rd_issue) begin
      rem_q <= rem_q - 1'b1;
    end
    if (cmd.rd_issue) begin
      pend_fill <= sel_count - 1'b1;
      pend_last <= (rem_q == REM_W'(1)) || (sel_count == FCNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_PIPES; i++) begin
        busy[i]  <= 1'b0;
        head[i]  <= '0;
        tail[i]  <= '0;
        count[i] <= '0;
      end
    end else begin
      if (cmd.single && (req_q == REQ_ALLOC) && free_found) begin
        busy[free_idx] <= 1'b1;
      end
      if (cmd.single && wr_ok) begin
        head[pidx]  <= head_inc;
        count[pidx] <= sel_count + 1'b1;
      end
      if (cmd.rd_issue) begin
        tail[pidx]  <= tail_inc;
        count[pidx] <= sel_count - 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.single || cmd.rd_push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.single) begin
      status         <= one_status;
      result_channel <= one_ch;
      read_byte      <= '0;
      fill_level     <= FILL_W'(one_fill);
      last           <= 1'b1;
    end else if (cmd.rd_push) begin
      status         <= ST_OK;
      result_channel <= ch_q;
      read_byte      <= rdata;
      fill_level     <= FILL_W'(pend_fill);
      last           <= pend_last;
    end
  end

endmodule

@@ design/multi_channel_byte_pipe.sv @@
// channel  | dir | tdata (low bit up)                          | tuser      | tlast
// ---------+-----+---------------------------------------------+------------+------
// s_axis   | in  | channel[2:0] write_byte[10:3] read_count[15:11] | req_type | -
// m_axis   | out | result_channel[2:0] read_byte[10:3]         | status     | last
//          |     | fill_level[17:11], zero pad [23:18]          |            |
//
// flow: an item is taken in the idle state and worked the next cycle; allocate,
//   write and items with no result then return to idle; a read of n bytes pops up to
//   min(n, MAX_BURST) bytes via the memory read port, one a cycle while unstalled
// reset: clears busy flags, head and tail indices and fill counts at once; the byte
//   memory is not cleared, it is only read where written
// stalls: m_tready low holds the output register and pauses a burst in place

module multi_channel_byte_pipe #(
  parameter int NUM_PIPES  = 8,
  parameter int PIPE_DEPTH = 64,
  parameter int MAX_BURST  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // channel, write_byte, read_count
  input  logic [1:0]  s_tuser,   // req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // result_channel, read_byte, fill_level, zero pad
  output logic [2:0]  m_tuser,   // status
  output logic        m_tlast
);

  import mcbp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  logic [CH_W-1:0]   result_channel;
  logic [BYTE_W-1:0] read_byte;
  logic [FILL_W-1:0] fill_level;

  // sequencer: one item at a time
  mcbp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // pipe state, byte memory and output register
  mcbp_dp #(
    .NUM_PIPES  (NUM_PIPES),
    .PIPE_DEPTH (PIPE_DEPTH),
    .MAX_BURST  (MAX_BURST)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .req_type       (s_tuser),
    .channel        (s_tdata[2:0]),
    .write_byte     (s_tdata[10:3]),
    .read_count     (s_tdata[15:11]),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .status         (m_tuser),
    .result_channel (result_channel),
    .read_byte      (read_byte),
    .fill_level     (fill_level),
    .last           (m_tlast)
  );

  assign m_tdata = {6'b0, fill_level, read_byte, result_channel};

`ifndef NO_ASSERTIONS
  // the output register is only loaded when it is empty or being drained
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.single || cmd.rd_push) |-> (!m_tvalid || m_tready))
    else $error("output register loaded while holding an item");

  // one item at a time: no second accept right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while an item is in work");

  // a result is never produced in the cycle an item is taken
  a_load_alone: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !(cmd.single || cmd.rd_issue || cmd.rd_push))
    else $error("item capture overlaps work on an item");
`endif

endmodule

@@ verif/tb_multi_channel_byte_pipe.sv @@
`timescale 1ns / 100ps

module tb_multi_channel_byte_pipe;
  import mcbp_pkg::*;

  localparam int NUM_PIPES    = 8;
  localparam int PIPE_DEPTH   = 64;
  localparam int MAX_BURST    = 16;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES  = 300;
  localparam int MAX_PRINTS   = 40;

  // request code the block leaves unused
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [CH_W-1:0]     chan;
    logic [BYTE_W-1:0]   data;
    logic [FILL_W-1:0]   fill;
    logic                last;
  } pipe_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;   // channel, write_byte, read_count
  logic [1:0]  s_tuser = '0;   // req_type
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;        // result_channel, read_byte, fill_level, zero pad
  logic [2:0]  m_tuser;        // status
  logic        m_tlast;

  multi_channel_byte_pipe #(
    .NUM_PIPES  (NUM_PIPES),
    .PIPE_DEPTH (PIPE_DEPTH),
    .MAX_BURST  (MAX_BURST)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // shadow of the pipe pool
  logic                    pipe_busy [NUM_PIPES];
  logic [5:0]              head_ptr  [NUM_PIPES];
  logic [5:0]              tail_ptr  [NUM_PIPES];
  logic [FILL_W-1:0]       fill_cnt  [NUM_PIPES];
  logic [BYTE_W-1:0]       pipe_mem  [NUM_PIPES][PIPE_DEPTH];

  pipe_result_t pending_results[$];

  int  error_count = 0;
  int  cycle_count = 0;
  int  tx_idle_pct = 0;
  int  rx_stall_pct = 0;
  bit  hold_rx = 1'b0;
  int  last_result_count;

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycle_count,
               pending_results.size());
      $display("** multi_channel_byte_pipe: FAILED **");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    error_count++;
    if (error_count <= MAX_PRINTS)
      $display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  function automatic void queue_result(logic [STATUS_W-1:0] st, logic [CH_W-1:0] ch,
                                       logic [BYTE_W-1:0] b, logic [FILL_W-1:0] fill,
                                       logic last);
    pipe_result_t r;
    r.status = st;
    r.chan   = ch;
    r.data   = b;
    r.fill   = fill;
    r.last   = last;
    pending_results.push_back(r);
  endfunction

  // works out the results of one request and updates the shadow pool
  function automatic int predict_request(logic [REQ_W-1:0] req, logic [CH_W-1:0] ch,
                                         logic [BYTE_W-1:0] wb, logic [RCNT_W-1:0] cnt);
    int n;
    int burst;
    bit found;
    logic [BYTE_W-1:0] b;
    n = 0;
    found = 1'b0;
    case (req)
      REQ_ALLOC: begin
        for (int i = 0; i < NUM_PIPES; i++) begin
          if (!found && !pipe_busy[i]) begin
            found = 1'b1;
            pipe_busy[i] = 1'b1;
            queue_result(ST_OK, CH_W'(i), '0, fill_cnt[i], 1'b1);
          end
        end
        if (!found)
          queue_result(ST_NONE, '0, '0, '0, 1'b1);
        n = 1;
      end
      REQ_WRITE: begin
        n = 1;
        if (int'(ch) >= NUM_PIPES || !pipe_busy[ch]) begin
          queue_result(ST_INVALID, ch, '0, '0, 1'b1);
        end else if (fill_cnt[ch] >= PIPE_DEPTH) begin
          queue_result(ST_FULL, ch, '0, fill_cnt[ch], 1'b1);
        end else begin
          pipe_mem[ch][head_ptr[ch]] = wb;
          head_ptr[ch] = (head_ptr[ch] == PIPE_DEPTH - 1) ? '0 : head_ptr[ch] + 1'b1;
          fill_cnt[ch] = fill_cnt[ch] + 1'b1;
          queue_result(ST_OK, ch, '0, fill_cnt[ch], 1'b1);
        end
      end
      REQ_READ: begin
        if (cnt != 0) begin
          burst = (cnt > MAX_BURST) ? MAX_BURST : int'(cnt);
          if (int'(ch) >= NUM_PIPES || !pipe_busy[ch]) begin
            queue_result(ST_INVALID, ch, '0, '0, 1'b1);
            n = 1;
          end else if (fill_cnt[ch] == 0) begin
            queue_result(ST_EMPTY, ch, '0, '0, 1'b1);
            n = 1;
          end else begin
            while (n < burst && fill_cnt[ch] > 0) begin
              b = pipe_mem[ch][tail_ptr[ch]];
              tail_ptr[ch] = (tail_ptr[ch] == PIPE_DEPTH - 1) ? '0 : tail_ptr[ch] + 1'b1;
              fill_cnt[ch] = fill_cnt[ch] - 1'b1;
              n++;
              queue_result(ST_OK, ch, b, fill_cnt[ch], (n == burst) || (fill_cnt[ch] == 0));
            end
          end
        end
      end
      default: n = 0;
    endcase
    return n;
  endfunction

  // offers one item, with a random gap first, and predicts it once taken
  task automatic send_item(input logic [REQ_W-1:0] req, input logic [CH_W-1:0] ch,
                           input logic [BYTE_W-1:0] wb, input logic [RCNT_W-1:0] cnt);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= {cnt, wb, ch};
    do @(posedge clk); while (!s_tready);
    last_result_count = predict_request(req, ch, wb, cnt);
  endtask

  task automatic stop_sending();
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  task automatic wait_drain();
    stop_sending();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // receiver readiness, held low while a long stall is running
  always @(negedge clk) begin
    m_tready <= hold_rx ? 1'b0 : ($urandom_range(99) >= rx_stall_pct);
  end

  always @(posedge clk) begin : result_check
    pipe_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, status", int'(m_tuser), -1);
      end else begin
        want = pending_results.pop_front();
        if (m_tuser !== want.status)
          report_mismatch("status", int'(m_tuser), int'(want.status));
        if (m_tdata[2:0] !== want.chan)
          report_mismatch("result_channel", int'(m_tdata[2:0]), int'(want.chan));
        if (m_tdata[10:3] !== want.data)
          report_mismatch("read_byte", int'(m_tdata[10:3]), int'(want.data));
        if (m_tdata[17:11] !== want.fill)
          report_mismatch("fill_level", int'(m_tdata[17:11]), int'(want.fill));
        if (m_tlast !== want.last)
          report_mismatch("last", int'(m_tlast), int'(want.last));
      end
    end
  end

  // requests to pipes nobody has claimed yet, plus items that give nothing back
  task automatic test_free_pipes();
    send_item(REQ_WRITE, 3'd0, 8'h5a, 5'd1);
    send_item(REQ_READ, 3'd7, 8'h00, 5'd31);
    send_item(REQ_READ, 3'd3, 8'h00, 5'd0);
    send_item(REQ_UNUSED, 3'd7, 8'hff, 5'd31);
    send_item(REQ_READ, 3'd4, 8'h00, 5'd16);
    wait_drain();
  endtask

  task automatic test_read_write_edges();
    send_item(REQ_ALLOC, 3'd0, 8'h00, 5'd0);
    send_item(REQ_ALLOC, 3'd0, 8'h00, 5'd0);
    send_item(REQ_ALLOC, 3'd0, 8'h00, 5'd0);
    send_item(REQ_WRITE, 3'd5, 8'h33, 5'd0);   // still free
    send_item(REQ_READ, 3'd1, 8'h00, 5'd1);    // busy but empty
    send_item(REQ_WRITE, 3'd0, 8'h00, 5'd0);
    send_item(REQ_WRITE, 3'd0, 8'hff, 5'd31);
    send_item(REQ_READ, 3'd0, 8'h00, 5'd1);
    send_item(REQ_READ, 3'd0, 8'h00, 5'd0);    // no result, nothing popped
    send_item(REQ_READ, 3'd0, 8'h00, 5'd31);   // saturates, one byte left
    for (int i = 0; i < 3; i++)
      send_item(REQ_WRITE, 3'd2, 8'($urandom), 5'($urandom));
    send_item(REQ_READ, 3'd2, 8'h00, 5'd17);
    wait_drain();
  endtask

  task automatic test_allocation();
    for (int i = 0; i < 5; i++)
      send_item(REQ_ALLOC, 3'($urandom), 8'($urandom), 5'($urandom));
    send_item(REQ_ALLOC, 3'd0, 8'h00, 5'd0);   // pool exhausted
    send_item(REQ_WRITE, 3'd7, 8'ha5, 5'd0);
    send_item(REQ_READ, 3'd7, 8'h00, 5'd16);
    wait_drain();
  endtask

  // fill one pipe past its depth, then drain it in full bursts
  task automatic test_full_pipe(input logic [CH_W-1:0] ch);
    while (fill_cnt[ch] < PIPE_DEPTH)
      send_item(REQ_WRITE, ch, 8'($urandom), 5'($urandom));
    send_item(REQ_WRITE, ch, 8'hff, 5'd0);
    send_item(REQ_WRITE, ch, 8'h00, 5'd0);
    while (fill_cnt[ch] > 0)
      send_item(REQ_READ, ch, 8'($urandom), 5'd16);
    send_item(REQ_READ, ch, 8'h00, 5'd16);
    wait_drain();
  endtask

  task automatic send_random_item(input logic [CH_W-1:0] hot_ch);
    logic [REQ_W-1:0]  req;
    logic [CH_W-1:0]   ch;
    logic [RCNT_W-1:0] cnt;
    int pick;
    pick = $urandom_range(99);
    if (pick < 2)       req = REQ_UNUSED;
    else if (pick < 5)  req = REQ_ALLOC;
    else if (pick < 66) req = REQ_WRITE;
    else                req = REQ_READ;
    ch = ($urandom_range(99) < 40) ? hot_ch : CH_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 3)       cnt = 5'd0;
    else if (pick < 11) cnt = RCNT_W'($urandom_range(31, 17));
    else if (pick < 75) cnt = RCNT_W'($urandom_range(3, 1));
    else                cnt = RCNT_W'($urandom_range(16, 4));
    send_item(req, ch, 8'($urandom), cnt);
  endtask

  task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int n_items);
    int counted;
    counted = 0;
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    while (counted < n_items) begin
      send_random_item(CH_W'($urandom));
      if (last_result_count != 0)
        counted++;
    end
    wait_drain();
  endtask

  // receiver stalls for a long stretch while the sender keeps offering items
  task automatic test_output_stall();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    hold_rx = 1'b1;
    fork
      begin
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rx = 1'b0;
      end
      begin
        for (int i = 0; i < 30; i++)
          send_random_item(3'd6);
        send_item(REQ_READ, 3'd6, 8'h00, 5'd16);
      end
    join
    wait_drain();
  endtask

  initial begin
    for (int i = 0; i < NUM_PIPES; i++) begin
      pipe_busy[i] = 1'b0;
      head_ptr[i]  = '0;
      tail_ptr[i]  = '0;
      fill_cnt[i]  = '0;
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_free_pipes();
    test_read_write_edges();
    test_allocation();
    test_full_pipe(3'd3);
    test_random_traffic(6, 50, 70);
    test_random_traffic(50, 6, 70);
    test_random_traffic(0, 0, 70);
    test_output_stall();

    if (pending_results.size() != 0)
      report_mismatch("results never delivered", 0, pending_results.size());
    if (error_count == 0) begin
      $display("** multi_channel_byte_pipe: PASSED **");
    end else begin
      $display("** multi_channel_byte_pipe: FAILED **");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/mcbp_pkg.sv
design/mcbp_ram.sv
design/mcbp_ctrl.sv
design/mcbp_dp.sv
design/multi_channel_byte_pipe.sv
verif/tb_multi_channel_byte_pipe.sv
